@@ rtl/pzn_pkg.sv @@
// pzn_pkg: shared word types, job descriptor and mode codes
// no dependencies
package pzn_pkg;

  localparam int CNT_W = 7;
  localparam int SUM_W = 14;

  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_MEAN  = 2'd1;
  localparam logic [1:0] MODE_SCALE = 2'd2;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_pixel;
  } pzn_in_t;

  typedef struct packed {
    logic signed [17:0] norm_value;
    logic               last_out;
  } pzn_out_t;

  // one closed patch waiting for the back end
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] sum;
    logic [1:0]       mode;
    logic             bank;
  } pzn_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pzn_qstat_t;

endpackage

@@ rtl/patch_zscore_normalizer.sv @@
// patch z-score normalizer: pixels in one word per cycle while a store bank is free;
// results come out in pass through, with mean removal (24-step divider) or with
// deviation scaling (13-step root search) after a deviation-sum pass over the patch;
// output stalls hold each result until it is taken;
// synchronous active-low reset clears counters, queue and sequencer;
// the two-bank patch store is not cleared and only holds data once written
module patch_zscore_normalizer import pzn_pkg::*; #(
  parameter int PATCH_PIXELS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pzn_in_t    in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output pzn_out_t   out_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data
);

  // index width for one bank, at least one bit
  localparam int AW    = (PATCH_PIXELS > 1) ? $clog2(PATCH_PIXELS) : 1;
  localparam int DEPTH = 2 ** (AW + 1);

  // front to store
  logic          wr_en, wr_bank;
  logic [AW-1:0] wr_idx;
  logic [7:0]    wr_pixel;

  // front to queue to back
  logic          jq_push, jq_pop;
  pzn_job_t      push_job, head_job;
  pzn_qstat_t    q_stat;

  // back to store
  logic          rd_bank;
  logic [AW-1:0] rd_idx;
  logic [7:0]    rd_data_r;

  // patch store: two banks, front fills one while back drains the other
  logic [7:0]    mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_bank, wr_idx}] <= wr_pixel;
    end
    rd_data_r <= mem[{rd_bank, rd_idx}];
  end

  pzn_front #(.PATCH_PIXELS(PATCH_PIXELS), .AW(AW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .wr_en    (wr_en),
    .wr_bank  (wr_bank),
    .wr_idx   (wr_idx),
    .wr_pixel (wr_pixel),
    .job_push (jq_push),
    .job      (push_job)
  );

  // an entry stays queued until its last result leaves, so queue depth
  // equals the number of banks in use
  pzn_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (push_job),
    .pop      (jq_pop),
    .head     (head_job),
    .stat     (q_stat)
  );

  pzn_back #(.AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .job_avail (!q_stat.empty),
    .job_done  (jq_pop),
    .rd_bank   (rd_bank),
    .rd_idx    (rd_idx),
    .rd_pixel  (rd_data_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // a result word only exists for a patch still held in the queue
  a_out_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_stat.empty)
    else $error("result word without a queued patch");

  // final word of a patch releases its bank in the same cycle
  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_word.last_out) |-> jq_pop)
    else $error("last result did not release its bank");

  // the back end never reads the bank the front is filling while both are busy
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && out_valid) |-> (wr_bank != rd_bank))
    else $error("front and back share a bank");

endmodule

@@ rtl/pzn_front.sv @@
// pzn_front: accepts pixel words, keeps sum and count, writes the patch bank
// depends on pzn_pkg
module pzn_front import pzn_pkg::*; #(
  parameter int PATCH_PIXELS = 64,
  parameter int AW           = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pzn_in_t          in_word,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_data,
  input  pzn_qstat_t       q_stat,
  output logic             wr_en,
  output logic             wr_bank,
  output logic [AW-1:0]    wr_idx,
  output logic [7:0]       wr_pixel,
  output logic             job_push,
  output pzn_job_t         job
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             bank_r;
  logic [1:0]       mode_r;
  logic             accept;

  // both banks owned by queued patches: hold off
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign wr_en    = accept && (count_r < CNT_W'(PATCH_PIXELS));
  assign wr_bank  = bank_r;
  assign wr_idx   = count_r[AW-1:0];
  assign wr_pixel = in_word.pixel;
  assign job_push = accept && in_word.last_pixel;

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (wr_en) begin
      count_nxt = count_r + CNT_W'(1);
      sum_nxt   = sum_r + SUM_W'(in_word.pixel);
    end
  end

  assign job = '{n: count_nxt, sum: sum_nxt, mode: mode_r, bank: bank_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      bank_r  <= 1'b0;
      mode_r  <= MODE_PASS;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      if (job_push) begin
        count_r <= '0;
        sum_r   <= '0;
        bank_r  <= !bank_r;
      end else begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

endmodule

@@ rtl/pzn_jobq.sv @@
// pzn_jobq: two-entry queue of closed patches, one per store bank
// depends on pzn_pkg
module pzn_jobq import pzn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pzn_job_t   push_job,
  input  logic       pop,
  output pzn_job_t   head,
  output pzn_qstat_t stat
);

  pzn_job_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head       = q_r[rp_r];
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/pzn_back.sv @@
// pzn_back: per-patch sequencer, deviation sum, divider and root search
// depends on pzn_pkg
module pzn_back import pzn_pkg::*; #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pzn_job_t      job,
  input  logic          job_avail,
  output logic          job_done,
  output logic          rd_bank,
  output logic [AW-1:0] rd_idx,
  input  logic [7:0]    rd_pixel,
  output logic          out_valid,
  input  logic          out_stall,
  output pzn_out_t      out_word
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_RD, ST_SQ_D, ST_SQ_M, ST_EL_RD, ST_EL_D,
    ST_DIV, ST_T1, ST_T2, ST_ROOT, ST_FIN, ST_OUT
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    idx_r;
  logic signed [15:0]  d_r;
  logic [33:0]         ssum_r;
  logic [13:0]         mag_r;
  logic                neg_r;
  logic [27:0]         sq_r;
  logic [51:0]         t_r;
  logic [12:0]         x_r;
  logic [51:0]         y_r;
  logic [46:0]         z_r;
  logic [3:0]          k_r;
  logic [23:0]         num_r;
  logic [7:0]          rem_r;
  logic [16:0]         quo_r;
  logic [4:0]          cnt_r;
  logic                out_valid_r;
  pzn_out_t            out_word_r;

  logic [14:0]         prod_w;
  logic signed [15:0]  d_w, negd_w;
  logic [13:0]         mag_w;
  logic [31:0]         dsq_w;
  logic [8:0]          rem_sh;
  logic [7:0]          den_w;
  logic                ge_w;
  logic [60:0]         cand_w;
  logic                fit_w;
  logic [34:0]         tn_w;
  logic [13:0]         xr_w;
  logic [16:0]         qmag_w;
  logic signed [17:0]  qsig_w;
  logic                last_w, is_scale, is_pass;

  assign is_scale = (job.mode == MODE_SCALE);
  assign is_pass  = (job.mode == MODE_PASS);
  assign last_w   = (idx_r == job.n - CNT_W'(1));

  assign rd_bank  = job.bank;
  assign rd_idx   = idx_r[AW-1:0];

  // d = pixel*n - sum
  assign prod_w = 15'(rd_pixel) * 15'(job.n);
  assign d_w    = $signed({1'b0, prod_w}) - $signed({2'b00, job.sum});
  assign negd_w = -d_w;
  assign mag_w  = d_w[15] ? negd_w[13:0] : d_w[13:0];
  assign dsq_w  = 32'(d_r) * 32'(d_r);

  // restoring divide step
  assign den_w  = {job.n, 1'b0};
  assign rem_sh = {rem_r, num_r[23]};
  assign ge_w   = (rem_sh >= {1'b0, den_w});

  // root search step: (x + 2^k)^2 * s <= t
  assign cand_w = 61'(y_r) + (61'(z_r) << (5'(k_r) + 5'd1))
                + (61'(ssum_r) << (5'(k_r) << 1));
  assign fit_w  = (cand_w <= 61'(t_r));
  assign tn_w   = 35'(sq_r) * 35'(job.n);

  // q = (x + 1) / 2 rounds the odd bound back to the nearest
  assign xr_w   = 14'(x_r) + 14'd1;
  assign qmag_w = is_scale ? 17'(xr_w[13:1]) : quo_r;
  assign qsig_w = neg_r ? -$signed({1'b0, qmag_w}) : $signed({1'b0, qmag_w});

  assign job_done  = (state_r == ST_OUT) && !out_stall && out_word_r.last_out;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (job_avail) begin
            idx_r   <= '0;
            ssum_r  <= '0;
            state_r <= is_scale ? ST_SQ_RD : ST_EL_RD;
          end
        end
        ST_SQ_RD: state_r <= ST_SQ_D;
        ST_SQ_D: begin
          d_r     <= d_w;
          state_r <= ST_SQ_M;
        end
        ST_SQ_M: begin
          ssum_r <= ssum_r + 34'(dsq_w);
          if (last_w) begin
            idx_r   <= '0;
            state_r <= ST_EL_RD;
          end else begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= ST_SQ_RD;
          end
        end
        ST_EL_RD: state_r <= ST_EL_D;
        ST_EL_D: begin
          mag_r <= mag_w;
          neg_r <= d_w[15];
          if (is_pass) begin
            out_word_r  <= '{norm_value: $signed({2'b00, rd_pixel, 8'd0}),
                             last_out: last_w};
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end else if (is_scale) begin
            if (ssum_r == '0) begin
              out_word_r  <= '{norm_value: '0, last_out: last_w};
              out_valid_r <= 1'b1;
              state_r     <= ST_OUT;
            end else begin
              state_r <= ST_T1;
            end
          end else begin
            num_r   <= (24'(mag_w) << 9) + 24'(job.n);
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= 5'd23;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= ge_w ? 8'(rem_sh - {1'b0, den_w}) : rem_sh[7:0];
          quo_r <= {quo_r[15:0], ge_w};
          num_r <= {num_r[22:0], 1'b0};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= ST_FIN;
        end
        ST_T1: begin
          sq_r    <= 28'(mag_r) * 28'(mag_r);
          state_r <= ST_T2;
        end
        ST_T2: begin
          t_r     <= {tn_w[33:0], 18'd0};
          x_r     <= '0;
          y_r     <= '0;
          z_r     <= '0;
          k_r     <= 4'd12;
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (fit_w) begin
            x_r <= x_r | (13'd1 << k_r);
            y_r <= cand_w[51:0];
            z_r <= z_r + (47'(ssum_r) << k_r);
          end
          k_r <= k_r - 4'd1;
          if (k_r == 4'd0) state_r <= ST_FIN;
        end
        ST_FIN: begin
          out_word_r  <= '{norm_value: qsig_w, last_out: last_w};
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_word_r.last_out) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_r + CNT_W'(1);
              state_r <= ST_EL_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for patch_zscore_normalizer
// depends on pzn_pkg and rtl/patch_zscore_normalizer.sv; reads nothing else
module tb_top import pzn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // mode three, not named by the block
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  pzn_in_t    in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pzn_out_t   out_word;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_data = '0;

  always #5 clk = ~clk;

  patch_zscore_normalizer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // pixel words waiting to be offered, normalized words waiting to come out
  pzn_in_t  pixel_q[$];
  pzn_out_t norm_q[$];

  // own copy of the block state
  logic [7:0]  patch_mem[64];
  logic [13:0] run_sum = '0;
  logic [6:0]  run_count = '0;
  logic [1:0]  cur_mode = MODE_PASS;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int errors = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // largest q with (2q-1)^2 * s <= t, q limited to 0..4096
  function automatic longint unsigned root_round(longint unsigned t, longint unsigned s);
    longint unsigned lo, hi, mid, odd;
    lo = 0;
    hi = 4096;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      if (odd * odd * s <= t) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // absorb one accepted pixel word; on the last mark queue the whole patch
  task automatic absorb_pixel(pzn_in_t w);
    longint n, d, r;
    longint unsigned dev_sq, mag, q;
    pzn_out_t o;
    if (run_count < 7'd64) begin
      patch_mem[run_count] = w.pixel;
      run_sum = run_sum + 14'(w.pixel);
      run_count++;
    end
    if (!w.last_pixel) return;
    n = run_count;
    dev_sq = 0;
    if (cur_mode == MODE_SCALE)
      for (int i = 0; i < n; i++) begin
        d = longint'(patch_mem[i]) * n - longint'(run_sum);
        dev_sq += longint'(d * d);
      end
    for (int i = 0; i < n; i++) begin
      d = longint'(patch_mem[i]) * n - longint'(run_sum);
      mag = (d < 0) ? -d : d;
      if (cur_mode == MODE_PASS) begin
        r = longint'(patch_mem[i]) * 256;
      end else begin
        if (cur_mode == MODE_SCALE)
          // zero deviation gives all-zero output
          q = (dev_sq == 0) ? 0 : root_round(262144 * mag * mag * n, dev_sq);
        else
          // mean removal, also taken by the unused mode three
          q = (512 * mag + n) / (2 * n);
        r = (d < 0) ? -longint'(q) : longint'(q);
      end
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      o.norm_value = r[17:0];
      o.last_out = (i == n - 1);
      norm_q = {norm_q, o};
    end
    run_sum = '0;
    run_count = '0;
  endtask

  // driver: offer the next pending word unless idling; hold it while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) absorb_pixel(in_word);
      if (pixel_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_word  <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long hold-off counter so the patch banks fill and the input backs up
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_cnt++;
      if (hold_cnt >= 900) hold_done <= 1'b1;
    end
  end

  // monitor: check each accepted word, then pick the stall for the next cycle
  always @(posedge clk) begin
    pzn_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (norm_q.size() == 0) begin
        report($sformatf("unexpected word value=%0d last=%0b",
                         out_word.norm_value, out_word.last_out));
      end else begin
        want = norm_q.pop_front();
        if (out_word.norm_value !== want.norm_value)
          report($sformatf("norm_value got %0d want %0d",
                           out_word.norm_value, want.norm_value));
        if (out_word.last_out !== want.last_out)
          report($sformatf("last_out got %0b want %0b",
                           out_word.last_out, want.last_out));
      end
    end
    if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  function automatic void push_pixel(logic [7:0] p, logic lst);
    pzn_in_t w;
    w.pixel = p;
    w.last_pixel = lst;
    pixel_q = {pixel_q, w};
  endfunction

  // wait for the block to drain, then let the clock run on for safety
  task automatic drain();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_valid || norm_q.size() != 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
    @(posedge clk);
  endtask

  // random patch shapes; returns number of words queued
  function automatic int random_patch();
    int kind, len;
    logic [7:0] base;
    kind = $urandom_range(0, 19);
    base = 8'($urandom);
    if (kind == 0) begin
      // full 64-pixel patch
      len = 64;
      for (int i = 0; i < len; i++) push_pixel(8'($urandom), i == len - 1);
    end else if (kind == 1) begin
      // overlong patch, tail pixels get dropped
      len = $urandom_range(65, 70);
      for (int i = 0; i < len; i++) push_pixel(8'($urandom), i == len - 1);
    end else if (kind == 2) begin
      // noise: random marks, then closed
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) push_pixel(8'($urandom), 1'($urandom));
      push_pixel(8'($urandom), 1'b1);
      len++;
    end else if (kind == 3) begin
      // flat patch, zero deviation
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) push_pixel(base, i == len - 1);
    end else begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        push_pixel(($urandom_range(0, 7) == 0) ? {8{1'($urandom)}} : 8'($urandom),
                   i == len - 1);
    end
    return len;
  endfunction

  initial begin
    logic [1:0] phase_mode[6];
    int count;
    phase_mode = '{MODE_SCALE, MODE_MEAN, MODE_PASS, MODE_SCALE, MODE_SPARE, MODE_MEAN};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pass through extremes
    set_mode(MODE_PASS);
    push_pixel(8'd0, 1'b0); push_pixel(8'd255, 1'b0); push_pixel(8'd128, 1'b1);
    drain();
    // mean removal with extremes
    set_mode(MODE_MEAN);
    push_pixel(8'd0, 1'b0); push_pixel(8'd255, 1'b0);
    push_pixel(8'd7, 1'b0); push_pixel(8'd200, 1'b1);
    drain();
    // scaling: flat patch, two-pixel extremes, single pixel
    set_mode(MODE_SCALE);
    push_pixel(8'd10, 1'b0); push_pixel(8'd10, 1'b0); push_pixel(8'd10, 1'b1);
    push_pixel(8'd0, 1'b0); push_pixel(8'd255, 1'b1);
    push_pixel(8'd77, 1'b1);
    drain();
    // unused mode three
    set_mode(MODE_SPARE);
    push_pixel(8'd1, 1'b0); push_pixel(8'd254, 1'b0); push_pixel(8'd3, 1'b1);
    drain();

    // random phases: sender busy then receiver busy, swapped, then no idling but one long receiver hold
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(phase_mode[ph]);
      if (ph < 2) begin
        tx_idle_pct = 35; rx_idle_pct = 88;
      end else if (ph < 4) begin
        tx_idle_pct = 88; rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      count = 0;
      while (count < 58) count += random_patch();
      if (ph == 4) hold_go = 1'b1;
      drain();
    end

    if (errors == 0 && norm_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pzn_pkg.sv
rtl/pzn_front.sv
rtl/pzn_jobq.sv
rtl/pzn_back.sv
rtl/patch_zscore_normalizer.sv
tb/tb_top.sv
